// ===== rtl/supv_csr_pkg.sv =====
// Shared types and constants for the supervisor-aliased CSR file.
// Used by supervisor_aliased_csr_file and supv_csr_checker; no dependencies.
package supv_csr_pkg;

    localparam int XLEN           = 64;
    localparam int ADDR_W         = 12;
    localparam int CAUSE_W        = 6;
    localparam int CSR_COUNT_DEF  = 4096;

    localparam logic [XLEN-1:0] SSTATUS_MASK_RESET = 64'h0000_0003_000D_E162;

    // request kinds
    localparam logic [1:0] REQ_READ     = 2'd0;
    localparam logic [1:0] REQ_WRITE    = 2'd1;
    localparam logic [1:0] REQ_EXC_QRY  = 2'd2;
    localparam logic [1:0] REQ_INT_QRY  = 2'd3;

    // register addresses
    localparam logic [ADDR_W-1:0] A_SSTATUS = 12'h100;
    localparam logic [ADDR_W-1:0] A_SIE     = 12'h104;
    localparam logic [ADDR_W-1:0] A_SIP     = 12'h144;
    localparam logic [ADDR_W-1:0] A_MSTATUS = 12'h300;
    localparam logic [ADDR_W-1:0] A_MEDELEG = 12'h302;
    localparam logic [ADDR_W-1:0] A_MIDELEG = 12'h303;
    localparam logic [ADDR_W-1:0] A_MIE     = 12'h304;
    localparam logic [ADDR_W-1:0] A_MIP     = 12'h344;

    // sip view: mip bits 3, 7, 11 show on bits 1, 5, 9
    localparam int SIP_SSI = 1;
    localparam int SIP_STI = 5;
    localparam int SIP_SEI = 9;
    localparam int MIP_SSI = 3;
    localparam int MIP_STI = 7;
    localparam int MIP_SEI = 11;
    localparam logic [XLEN-1:0] SIP_VIEW_MASK =
        (64'd1 << SIP_SSI) | (64'd1 << SIP_STI) | (64'd1 << SIP_SEI);

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ADDR_W-1:0]  csr_addr;
        logic [XLEN-1:0]    write_value;
        logic [CAUSE_W-1:0] cause_index;
    } t_req;

    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic            delegated;
    } t_rsp;

endpackage

// ===== rtl/supervisor_aliased_csr_file.sv =====
// Top level of the supervisor-aliased CSR file: request pipe, CSR store, alias views.
// Depends on supv_csr_pkg.
//
//  Channel   Direction  Handshake                    Payload
//  request   in         i_req_valid / o_req_ready    i_req  (supv_csr_pkg::t_req)
//  response  out        o_rsp_valid / i_rsp_ready    o_rsp  (supv_csr_pkg::t_rsp)
//  config    in         i_cfg_we (no wait)           i_cfg_wdata (sstatus view mask)
//
// One request per cycle while o_req_ready is high. Reads and queries answer through the
// registered store read (the read stage) and then the response register.
// Writes give no response and finish at acceptance.
// After reset a clearing pass zeroes the store, with o_req_ready low.
// A stalled response holds the response register and the read stage behind it.
module supervisor_aliased_csr_file #(
    parameter int CSR_COUNT = supv_csr_pkg::CSR_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  supv_csr_pkg::t_req            i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output supv_csr_pkg::t_rsp            o_rsp,
    input  logic                          i_cfg_we,
    input  logic [supv_csr_pkg::XLEN-1:0] i_cfg_wdata
);

    localparam int XLEN = supv_csr_pkg::XLEN;
    localparam int AW   = $clog2(CSR_COUNT);
    localparam logic [supv_csr_pkg::ADDR_W:0] ADDR_LIMIT =
        (supv_csr_pkg::ADDR_W+1)'(CSR_COUNT);
    localparam logic [AW-1:0] LAST_IDX = AW'(CSR_COUNT - 1);

    logic [XLEN-1:0] r_mem [CSR_COUNT];
    logic [XLEN-1:0] r_mem_q;

    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_idx;

    logic [XLEN-1:0] r_view_mask;
    logic [XLEN-1:0] r_mstatus, r_medeleg, r_mideleg, r_mie, r_mip;
    logic [XLEN-1:0] n_mstatus, n_medeleg, n_mideleg, n_mie, n_mip;

    logic            r_s1_vld;
    logic            r_s1_use_mem;
    logic [XLEN-1:0] r_s1_data;
    logic            r_s1_deleg;

    logic            r_out_vld;
    supv_csr_pkg::t_rsp r_out;

    logic            out_free, s1_move, s1_free, acc;
    logic            acc_rsp, acc_wr;
    logic            in_range;
    logic [AW-1:0]   mem_idx;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [XLEN-1:0] mem_wdata;
    logic            n_use_mem;
    logic [XLEN-1:0] n_data;
    logic            n_deleg;
    logic [XLEN-1:0] sip_view;
    logic [XLEN-1:0] wv;

    assign out_free    = !r_out_vld || i_rsp_ready;
    assign s1_move     = r_s1_vld && out_free;
    assign s1_free     = !r_s1_vld || s1_move;
    assign o_req_ready = !r_clr_busy && s1_free;
    assign acc         = i_req_valid && o_req_ready;
    assign acc_wr      = acc && (i_req.req_type == supv_csr_pkg::REQ_WRITE);
    assign acc_rsp     = acc && (i_req.req_type != supv_csr_pkg::REQ_WRITE);

    assign in_range = {1'b0, i_req.csr_addr} < ADDR_LIMIT;
    assign mem_idx  = i_req.csr_addr[AW-1:0];
    assign wv       = i_req.write_value;

    always_comb begin
        sip_view = '0;
        sip_view[supv_csr_pkg::SIP_SSI] = r_mideleg[supv_csr_pkg::SIP_SSI]
                                        & r_mip[supv_csr_pkg::MIP_SSI];
        sip_view[supv_csr_pkg::SIP_STI] = r_mideleg[supv_csr_pkg::SIP_STI]
                                        & r_mip[supv_csr_pkg::MIP_STI];
        sip_view[supv_csr_pkg::SIP_SEI] = r_mideleg[supv_csr_pkg::SIP_SEI]
                                        & r_mip[supv_csr_pkg::MIP_SEI];
    end

    // Result for reads and queries, except plain store reads which come from r_mem_q
    always_comb begin
        n_use_mem = 1'b0;
        n_data    = '0;
        n_deleg   = 1'b0;
        case (i_req.req_type)
            supv_csr_pkg::REQ_EXC_QRY: n_deleg = r_medeleg[i_req.cause_index];
            supv_csr_pkg::REQ_INT_QRY: n_deleg = r_mideleg[i_req.cause_index];
            default: begin
                case (i_req.csr_addr)
                    supv_csr_pkg::A_SIE:     n_data = r_mie & r_mideleg;
                    supv_csr_pkg::A_SIP:     n_data = sip_view;
                    supv_csr_pkg::A_SSTATUS: n_data = r_mstatus & r_view_mask;
                    supv_csr_pkg::A_MSTATUS: n_data = r_mstatus;
                    supv_csr_pkg::A_MEDELEG: n_data = r_medeleg;
                    supv_csr_pkg::A_MIDELEG: n_data = r_mideleg;
                    supv_csr_pkg::A_MIE:     n_data = r_mie;
                    supv_csr_pkg::A_MIP:     n_data = r_mip;
                    default:                 n_use_mem = in_range;
                endcase
            end
        endcase
    end

    // Write decode: aliased and machine registers live in flops, the rest in the store; also drives the clearing writes
    always_comb begin
        n_mstatus = r_mstatus;
        n_medeleg = r_medeleg;
        n_mideleg = r_mideleg;
        n_mie     = r_mie;
        n_mip     = r_mip;
        mem_we    = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        if (r_clr_busy) begin
            mem_we = 1'b1;
        end else if (acc_wr) begin
            case (i_req.csr_addr)
                supv_csr_pkg::A_SIE:     n_mie = (r_mie & ~r_mideleg) | (wv & r_mideleg);
                supv_csr_pkg::A_SIP:     n_mip = (r_mip & ~r_mideleg) | (wv & r_mideleg);
                supv_csr_pkg::A_SSTATUS:
                    n_mstatus = (r_mstatus & ~r_view_mask) | (wv & r_view_mask);
                supv_csr_pkg::A_MSTATUS: n_mstatus = wv;
                supv_csr_pkg::A_MEDELEG: n_medeleg = wv;
                supv_csr_pkg::A_MIDELEG: n_mideleg = wv;
                supv_csr_pkg::A_MIE:     n_mie = wv;
                supv_csr_pkg::A_MIP:     n_mip = wv;
                default: begin
                    mem_we    = in_range;
                    mem_waddr = mem_idx;
                    mem_wdata = wv;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (acc_rsp) begin
            r_mem_q <= r_mem[mem_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_view_mask <= supv_csr_pkg::SSTATUS_MASK_RESET;
            r_mstatus   <= '0;
            r_medeleg   <= '0;
            r_mideleg   <= '0;
            r_mie       <= '0;
            r_mip       <= '0;
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_view_mask <= i_cfg_wdata;
            end
            r_mstatus <= n_mstatus;
            r_medeleg <= n_medeleg;
            r_mideleg <= n_mideleg;
            r_mie     <= n_mie;
            r_mip     <= n_mip;
            if (s1_free) begin
                r_s1_vld <= acc_rsp;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_rsp) begin
            r_s1_use_mem <= n_use_mem;
            r_s1_data    <= n_data;
            r_s1_deleg   <= n_deleg;
        end
        if (s1_move) begin
            r_out.read_data <= r_s1_use_mem ? r_mem_q : r_s1_data;
            r_out.delegated <= r_s1_deleg;
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

// ===== rtl/supv_csr_checker.sv =====
// Port-level checker for supervisor_aliased_csr_file, attached by bind.
// Depends on supv_csr_pkg.
module supv_csr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          o_req_ready,
    input supv_csr_pkg::t_req            i_req,
    input logic                          o_rsp_valid,
    input logic                          i_rsp_ready,
    input supv_csr_pkg::t_rsp            o_rsp,
    input logic                          i_cfg_we,
    input logic [supv_csr_pkg::XLEN-1:0] i_cfg_wdata
);

    logic acc;
    assign acc = i_req_valid && o_req_ready;

    // store clearing keeps requests out right after reset
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready && !o_rsp_valid)
        else $error("request ready or response valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed or dropped");

    // sip view only carries the three supervisor interrupt bits
    a_sip_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == supv_csr_pkg::REQ_READ
             && i_req.csr_addr == supv_csr_pkg::A_SIP) ##1 i_rsp_ready
        |=> o_rsp_valid && ((o_rsp.read_data & ~supv_csr_pkg::SIP_VIEW_MASK) == '0)
            && !o_rsp.delegated)
        else $error("sip read shows bits outside its view");

    a_query_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.req_type == supv_csr_pkg::REQ_EXC_QRY
              || i_req.req_type == supv_csr_pkg::REQ_INT_QRY)) ##1 i_rsp_ready
        |=> o_rsp_valid && (o_rsp.read_data == '0))
        else $error("delegation query returned nonzero data");

    a_cfg_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == supv_csr_pkg::REQ_READ
             && i_req.csr_addr == supv_csr_pkg::A_SSTATUS && i_cfg_we
             && i_cfg_wdata == '0) ##1 i_rsp_ready
        |=> o_rsp_valid && !o_rsp.delegated)
        else $error("read response missing or flagged as delegated");

endmodule

bind supervisor_aliased_csr_file supv_csr_checker u_supv_csr_checker (.*);
